/* rtl/rthsv_pkg.sv */
// Shared types and constants for the RGB to HSV pixel core.
// No dependencies; imported by every module of the core.
package rthsv_pkg;

  localparam int PIX_W    = 8;   // channel width
  localparam int SCALE_W  = 10;  // scale register width
  localparam int OUT_W    = 18;  // result width, 8 fraction bits
  localparam int FRAC_W   = 8;
  localparam int SECT_W   = 11;  // sector numerator, up to 6*255
  localparam int DIV_NW   = 30;  // dividend width
  localparam int DIV_DW   = 12;  // divisor width, up to 12*255
  localparam int FRONT_STAGES = 2;
  localparam int LATENCY  = FRONT_STAGES + OUT_W;
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HUE_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;

  localparam logic [SCALE_W-1:0] HUE_SCALE_RST  = 10'd360;
  localparam logic [SCALE_W-1:0] FULL_SCALE_RST = 10'd100;

  // brightness dividend carries half of 2 * 255 for rounding
  localparam logic [DIV_NW-1:0] VAL_RND = 30'd255;

  // brightness: floor(num / 510) = floor((num / 2) / 255), and num / 2 is
  // below 2^26; x / 255 = (x * ceil(2^35 / 255)) >> 35 is exact there
  localparam int VAL_X_W   = 26;
  localparam int VAL_RCP_W = 28;
  localparam int VAL_SH    = 35;
  localparam logic [VAL_RCP_W-1:0] VAL_RECIP = 28'd134744073;

  typedef struct packed {
    logic [SCALE_W-1:0] hue_scale;
    logic [SCALE_W-1:0] full_scale;
  } cfg_t;

  // one division job: rounded quotient = floor(num / den)
  typedef struct packed {
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_job_t;

endpackage

/* rtl/rgb_to_hsv_pixel_core.sv */
// Top level of the RGB to HSV pixel core: config registers, front end,
// two pipelined dividers, the brightness constant divider and the valid
// pipe. Depends on rthsv_pkg.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-------------------------
//  input   | in_red, in_green, in_blue              | start & !busy
//  result  | out_hue, out_saturation, out_brightness| out_valid, one cycle
//  config  | cfg_index, cfg_data                    | cfg_valid & cfg_ready
//
// One word enters per clock; busy is never raised.
// Two front-end stages (sector select, then the scale multiplies) and
// 18 divider stages, one quotient bit each; the brightness path
// multiplies by a reciprocal and then delays to match.
// Synchronous active-low reset clears the valid pipe and loads the
// scale defaults (hue 360, full scale 100). The receiver cannot stall, so
// results stream out on out_valid with no backpressure path.
module rgb_to_hsv_pixel_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [rthsv_pkg::PIX_W-1:0]       in_red,
  input  logic [rthsv_pkg::PIX_W-1:0]       in_green,
  input  logic [rthsv_pkg::PIX_W-1:0]       in_blue,
  output logic                              out_valid,
  output logic [rthsv_pkg::OUT_W-1:0]       out_hue,
  output logic [rthsv_pkg::OUT_W-1:0]       out_saturation,
  output logic [rthsv_pkg::OUT_W-1:0]       out_brightness,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rthsv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rthsv_pkg::SCALE_W-1:0]     cfg_data
);
  import rthsv_pkg::*;

  cfg_t       cfg_r;
  logic       in_fire;
  logic       front_vld;
  div_job_t   hue_job, sat_job;
  logic [DIV_NW-1:0] val_num;
  logic [OUT_W-1:0] vld_r;  // one valid bit per divider stage

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_fire   = start & ~busy;

  // scale registers; out-of-range index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hue_scale  <= HUE_SCALE_RST;
      cfg_r.full_scale <= FULL_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HUE_SCALE:  cfg_r.hue_scale  <= cfg_data;
        REG_FULL_SCALE: cfg_r.full_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  rthsv_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (in_fire),
    .red_i   (in_red),
    .green_i (in_green),
    .blue_i  (in_blue),
    .cfg_i   (cfg_r),
    .vld_o   (front_vld),
    .hue_o   (hue_job),
    .sat_o   (sat_job),
    .val_o   (val_num)
  );

  rthsv_div  u_div_hue (.clk(clk), .job_i(hue_job), .quot_o(out_hue));
  rthsv_div  u_div_sat (.clk(clk), .job_i(sat_job), .quot_o(out_saturation));
  rthsv_cdiv u_div_val (.clk(clk), .num_i(val_num), .quot_o(out_brightness));

  // valid bits ride alongside the divider stages
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[OUT_W-2:0], front_vld};
  end

  assign out_valid = vld_r[OUT_W-1];

endmodule

/* rtl/rthsv_front.sv */
// Front end: channel max/min, hue sector numerator, then scaled dividends.
// Depends on rthsv_pkg. Two register stages.
module rthsv_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  vld_i,
  input  logic [rthsv_pkg::PIX_W-1:0] red_i,
  input  logic [rthsv_pkg::PIX_W-1:0] green_i,
  input  logic [rthsv_pkg::PIX_W-1:0] blue_i,
  input  rthsv_pkg::cfg_t       cfg_i,
  output logic                  vld_o,
  output rthsv_pkg::div_job_t   hue_o,
  output rthsv_pkg::div_job_t   sat_o,
  output logic [rthsv_pkg::DIV_NW-1:0] val_o
);
  import rthsv_pkg::*;

  logic [PIX_W-1:0]  mx, mn, d;
  logic [SECT_W-1:0] d11, num_nxt;

  logic              vld_a_r;
  logic [SECT_W-1:0] num_a_r;
  logic [PIX_W-1:0]  d_a_r, mx_a_r;

  logic                    vld_b_r;
  div_job_t                hue_nxt, sat_nxt;
  div_job_t                hue_r, sat_r;
  logic [DIV_NW-1:0]       val_nxt, val_r;
  logic [2*SECT_W-2:0]     hprod;
  logic [SCALE_W+PIX_W-1:0] sprod, vprod;

  always_comb begin
    mx = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    d   = mx - mn;
    d11 = SECT_W'(d);
    // ties go red, then green
    if (mx == red_i) begin
      if (green_i >= blue_i) num_nxt = SECT_W'(green_i) - SECT_W'(blue_i);
      else num_nxt = 3'd6 * d11 - (SECT_W'(blue_i) - SECT_W'(green_i));
    end else if (mx == green_i) begin
      num_nxt = 2'd2 * d11 + SECT_W'(blue_i) - SECT_W'(red_i);
    end else begin
      num_nxt = 3'd4 * d11 + SECT_W'(red_i) - SECT_W'(green_i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_a_r <= 1'b0;
    else vld_a_r <= vld_i;
    num_a_r <= num_nxt;
    d_a_r   <= d;
    mx_a_r  <= mx;
  end

  // dividends carry the half-divisor for round-to-nearest
  always_comb begin
    hprod = (2*SECT_W-1)'(cfg_i.hue_scale) * (2*SECT_W-1)'(num_a_r);
    sprod = (SCALE_W+PIX_W)'(cfg_i.full_scale) * (SCALE_W+PIX_W)'(d_a_r);
    vprod = (SCALE_W+PIX_W)'(cfg_i.full_scale) * (SCALE_W+PIX_W)'(mx_a_r);
    if (d_a_r == '0) begin
      // grey pixel: force zero quotient
      hue_nxt.num = '0;
      hue_nxt.den = DIV_DW'(1);
      sat_nxt.num = '0;
      sat_nxt.den = DIV_DW'(1);
    end else begin
      hue_nxt.num = (DIV_NW'(hprod) << (FRAC_W + 1)) + DIV_NW'(3'd6 * SECT_W'(d_a_r));
      hue_nxt.den = DIV_DW'(4'd12) * DIV_DW'(d_a_r);
      sat_nxt.num = (DIV_NW'(sprod) << (FRAC_W + 1)) + DIV_NW'(mx_a_r);
      sat_nxt.den = DIV_DW'(mx_a_r) << 1;
    end
    val_nxt = (DIV_NW'(vprod) << (FRAC_W + 1)) + VAL_RND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_b_r <= 1'b0;
    else vld_b_r <= vld_a_r;
    hue_r <= hue_nxt;
    sat_r <= sat_nxt;
    val_r <= val_nxt;
  end

  assign vld_o = vld_b_r;
  assign hue_o = hue_r;
  assign sat_o = sat_r;
  assign val_o = val_r;

endmodule

/* rtl/rthsv_div.sv */
// Pipelined restoring divider, one quotient bit per stage, and the
// constant divider for brightness. Depends on rthsv_pkg.
// Quotients are known to fit OUT_W bits.
module rthsv_div (
  input  logic                       clk,
  input  rthsv_pkg::div_job_t        job_i,
  output logic [rthsv_pkg::OUT_W-1:0] quot_o
);
  import rthsv_pkg::*;

  logic [DIV_NW-1:0] rem_r  [OUT_W];
  logic [DIV_DW-1:0] den_r  [OUT_W];
  logic [OUT_W-1:0]  quot_r [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    localparam int SH = OUT_W - 1 - k;
    logic [DIV_NW-1:0] rem_in, trial;
    logic [DIV_DW-1:0] den_in;
    logic [OUT_W-1:0]  q_in;

    if (k == 0) begin : g_first
      assign rem_in = job_i.num;
      assign den_in = job_i.den;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign q_in   = quot_r[k-1];
    end

    assign trial = DIV_NW'(den_in) << SH;

    always_ff @(posedge clk) begin
      den_r[k] <= den_in;
      if (rem_in >= trial) begin
        rem_r[k]  <= rem_in - trial;
        quot_r[k] <= q_in | (OUT_W'(1) << SH);
      end else begin
        rem_r[k]  <= rem_in;
        quot_r[k] <= q_in;
      end
    end
  end

  assign quot_o = quot_r[OUT_W-1];

endmodule

// Divide by 510 through a reciprocal multiply, then a delay line so the
// quotient lines up with the restoring dividers.
module rthsv_cdiv (
  input  logic                          clk,
  input  logic [rthsv_pkg::DIV_NW-1:0]  num_i,
  output logic [rthsv_pkg::OUT_W-1:0]   quot_o
);
  import rthsv_pkg::*;

  logic [VAL_X_W-1:0]           x;
  logic [VAL_X_W+VAL_RCP_W-1:0] prod;
  logic [OUT_W-1:0]             q_r [OUT_W];

  assign x    = VAL_X_W'(num_i >> 1);
  assign prod = (VAL_X_W+VAL_RCP_W)'(x) * (VAL_X_W+VAL_RCP_W)'(VAL_RECIP);

  always_ff @(posedge clk) begin
    q_r[0] <= OUT_W'(prod >> VAL_SH);
    for (int k = 1; k < OUT_W; k++) q_r[k] <= q_r[k-1];
  end

  assign quot_o = q_r[OUT_W-1];

endmodule

/* rtl/rthsv_checker.sv */
// Port-level checks for rgb_to_hsv_pixel_core, bound to the top level.
// Depends on rthsv_pkg.
module rthsv_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic [rthsv_pkg::PIX_W-1:0]     in_red,
  input logic [rthsv_pkg::PIX_W-1:0]     in_green,
  input logic [rthsv_pkg::PIX_W-1:0]     in_blue,
  input logic                            out_valid,
  input logic [rthsv_pkg::OUT_W-1:0]     out_hue,
  input logic                            cfg_ready
);
  import rthsv_pkg::*;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result word without input word");

  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_red == in_green && in_green == in_blue)
      |-> ##LATENCY (out_valid && out_hue == '0))
    else $error("grey pixel gave nonzero hue or was lost");

endmodule

bind rgb_to_hsv_pixel_core rthsv_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
  .out_valid(out_valid), .out_hue(out_hue), .cfg_ready(cfg_ready)
);

/* tb/rgb_to_hsv_pixel_checker.sv */
// Checker for the RGB to HSV pixel core: predicts each result from the
// accepted pixel and the scale registers, and compares. Depends on rthsv_pkg.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic [rthsv_pkg::PIX_W-1:0]     in_red,
  input  logic [rthsv_pkg::PIX_W-1:0]     in_green,
  input  logic [rthsv_pkg::PIX_W-1:0]     in_blue,
  input  logic                            out_valid,
  input  logic [rthsv_pkg::OUT_W-1:0]     out_hue,
  input  logic [rthsv_pkg::OUT_W-1:0]     out_saturation,
  input  logic [rthsv_pkg::OUT_W-1:0]     out_brightness,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [rthsv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rthsv_pkg::SCALE_W-1:0]   cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import rthsv_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] hue;
    logic [OUT_W-1:0] sat;
    logic [OUT_W-1:0] val;
  } hsv_t;

  hsv_t expected_hsv[$];
  logic [SCALE_W-1:0] hue_scale_q;
  logic [SCALE_W-1:0] full_scale_q;

  function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
    return (2 * n + d) / (2 * d);
  endfunction

  function automatic hsv_t convert_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    longint unsigned mx, mn, dl, num;
    hsv_t res;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    if (dl == 0) begin
      res.hue = '0;
    end else begin
      // sector position in units of delta, ties to red then green
      if (mx == r) num = (g >= b) ? (g - b) : (6 * dl - (b - g));
      else if (mx == g) num = 2 * dl + b - r;
      else num = 4 * dl + r - g;
      res.hue = OUT_W'(rdiv(256 * hue_scale_q * num, 6 * dl));
    end
    res.sat = (mx == 0) ? '0 : OUT_W'(rdiv(256 * full_scale_q * dl, mx));
    res.val = OUT_W'(rdiv(256 * full_scale_q * mx, 255));
    return res;
  endfunction

  always @(posedge clk) begin
    hsv_t e;
    if (!rst_n) begin
      hue_scale_q  <= HUE_SCALE_RST;
      full_scale_q <= FULL_SCALE_RST;
      expected_hsv.delete();
      fail_count   <= 0;
      pending      <= 0;
    end else begin
      if (start && !busy)
        expected_hsv.push_back(convert_pixel(in_red, in_green, in_blue));
      if (out_valid) begin
        if (expected_hsv.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result word at %0t", $realtime);
        end else begin
          e = expected_hsv.pop_front();
          if (e.hue !== out_hue || e.sat !== out_saturation || e.val !== out_brightness) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp h=%0d s=%0d v=%0d got h=%0d s=%0d v=%0d",
                       e.hue, e.sat, e.val, out_hue, out_saturation, out_brightness);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HUE_SCALE) hue_scale_q <= cfg_data;
        else if (cfg_index == REG_FULL_SCALE) full_scale_q <= cfg_data;
      end
      pending <= expected_hsv.size();
    end
  end

endmodule

/* tb/rgb_to_hsv_pixel_core_tb.sv */
// Testbench top for the RGB to HSV pixel core: drives pixels and scale
// writes, gives the verdict. Depends on rthsv_pkg and the checker module.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_core_tb;
  import rthsv_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [PIX_W-1:0]     in_red, in_green, in_blue;
  logic                 out_valid;
  logic [OUT_W-1:0]     out_hue, out_saturation, out_brightness;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SCALE_W-1:0]   cfg_data;
  int                   fail_count;
  int                   pending;
  int                   cycle_count;
  bit                   no_gaps;  // set during the burst stretch

  rgb_to_hsv_pixel_core dut (.*);

  rgb_to_hsv_pixel_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // watchdog: bound covers 1200+ words with their idle gaps and drains, many times over
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 200000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // one pixel word; idles ~29% unless in the burst stretch.
  // start stays high on return so words can follow back to back.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while (!no_gaps && $urandom_range(99) < 29) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start    <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // scale write; only called with the pipe drained
  task automatic write_scale(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // wait for every expected word plus the pipeline depth
  task automatic drain;
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic random_pixels(int n);
    logic [7:0] r, g, b;
    for (int i = 0; i < n; i++) begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case ($urandom_range(7))
        0: begin g = r; b = r; end           // grey
        1: g = r;                            // red/green tie
        2: b = g;                            // green/blue tie
        3: begin r = 8'hFF; b = 8'($urandom_range(3)); end
        default: ;
      endcase
      send_pixel(r, g, b);
    end
  endtask

  initial begin
    start = 0; in_red = 0; in_green = 0; in_blue = 0;
    cfg_valid = 0; cfg_index = REG_HUE_SCALE; cfg_data = '0;
    no_gaps = 0;
    rst_n = 0;
    repeat (12) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: extremes, each sector, ties, grey, black, red wrap
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd170, 8'd85, 8'd42);
    send_pixel(8'd85, 8'd170, 8'd42);
    send_pixel(8'd42, 8'd85, 8'd170);
    send_pixel(8'd200, 8'd10, 8'd100);
    drain();

    // each phase: scale writes, then random pixels (phase 0 first sends two directed ones)
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_scale(REG_HUE_SCALE, 10'd1023); write_scale(REG_FULL_SCALE, 10'd1023); end
        1: begin write_scale(REG_HUE_SCALE, 10'd1); write_scale(REG_FULL_SCALE, 10'd1); end
        2: begin write_scale(REG_HUE_SCALE, 10'd0); write_scale(REG_FULL_SCALE, 10'd0); end
        3: write_scale(2'd3, 10'h2AA);  // out-of-range index, ignored
        4: begin
          write_scale(REG_HUE_SCALE, SCALE_W'($urandom));
          write_scale(REG_FULL_SCALE, SCALE_W'($urandom));
        end
        default: begin write_scale(REG_HUE_SCALE, 10'd360); write_scale(REG_FULL_SCALE, 10'd100); end
      endcase
      if (ph == 0) begin
        send_pixel(8'd255, 8'd0, 8'd1);  // wrap at top scale
        send_pixel(8'd255, 8'd255, 8'd255);
      end
      if (ph == 5) no_gaps = 1;
      random_pixels(200);
      no_gaps = 0;
      drain();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* rgb_to_hsv_pixel_core.f */
rtl/rthsv_pkg.sv
rtl/rthsv_front.sv
rtl/rthsv_div.sv
rtl/rgb_to_hsv_pixel_core.sv
rtl/rthsv_checker.sv
tb/rgb_to_hsv_pixel_checker.sv
tb/rgb_to_hsv_pixel_core_tb.sv
